/* sv/radix_digit_accumulator_macros.svh */
// Assertion macros used by the radix digit accumulator top level.
`ifndef RADIX_DIGIT_ACCUMULATOR_MACROS_SVH
`define RADIX_DIGIT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rda_pkg.sv */
// Shared types, constants and the character classifier of the radix digit accumulator.
package rda_pkg;

  // Internal widths of the accumulator and the digit counter.
  localparam int VALUE_WIDTH = 64;
  localparam int COUNT_WIDTH = 16;

  // Port field widths.
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;
  localparam int LIMIT_W  = 63;
  localparam int OUT_W    = 64;
  localparam int STATUS_W = 2;
  localparam int DCOUNT_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Digit code for a character that is no digit in any base.
  localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 6'd63;

  // Character codes used by the classifier.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_NO_DIGITS = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX          = 4'd0,
    REG_LIMIT_QUOTIENT = 4'd1,
    REG_LIMIT_DIGIT    = 4'd2,
    REG_ERROR_VALUE    = 4'd3
  } reg_index_t;

  // One classified character: a digit of the current base or a terminator.
  typedef struct packed {
    logic               term;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  // Head of the token queue as seen by the back end.
  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_head_t;

  // Case-insensitive digit value of a character, NOT_A_DIGIT otherwise.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff = c - CH_ZERO;
      return diff[DIGIT_W-1:0];
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      diff = c - CH_UP_A + LETTER_OFS;
      return diff[DIGIT_W-1:0];
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      diff = c - CH_LO_A + LETTER_OFS;
      return diff[DIGIT_W-1:0];
    end
    return NOT_A_DIGIT;
  endfunction

endpackage

/* sv/rda_front.sv */
// Front end: accepts characters and classifies each as a digit or a terminator.
module rda_front import rda_pkg::*; (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic [DIGIT_W-1:0] radix,
  input  logic               q_full,
  output logic               q_push,
  output token_t             q_tok
);

  logic [DIGIT_W-1:0] digit;

  // A character is a digit when its value lies below the configured base.
  always_comb begin
    digit       = digit_of(s_tdata);
    q_tok.digit = digit;
    q_tok.term  = !(digit < radix);
  end

  // The front stalls only when the queue has no room.
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

endmodule

/* sv/rda_queue.sv */
// Two-entry token queue between the front end and the back end.
module rda_queue import rda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  token_t      push_tok,
  input  logic        pop,
  output logic        full,
  output queue_head_t head
);

  token_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.tok   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_tok;
  end

endmodule

/* sv/rda_back.sv */
// Back end: accumulates digits, detects overflow and holds the finished result.
module rda_back import rda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  queue_head_t         head,
  output logic                pop,
  input  logic [DIGIT_W-1:0]  radix,
  input  logic [LIMIT_W-1:0]  limit_quotient,
  input  logic [DIGIT_W-1:0]  limit_digit,
  input  logic [OUT_W-1:0]    error_value,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [OUT_W-1:0]    res_value,
  output status_t             res_status,
  output logic [DCOUNT_W-1:0] res_count,
  output logic                res_force
);

  logic [VALUE_WIDTH-1:0] acc;
  logic                   seen;
  logic                   ovf;
  logic [COUNT_WIDTH-1:0] cnt;

  logic [VALUE_WIDTH-1:0] acc_next;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic                   in_range;
  logic                   take_digit;
  logic                   take_term;

  // A digit always proceeds; a terminator waits for the result register.
  assign take_digit = head.valid && !head.tok.term;
  assign take_term  = head.valid && head.tok.term && (!res_valid || res_ready);
  assign pop        = take_digit || take_term;

  // Limit check and the multiply-add run side by side.
  always_comb begin
    in_range = (OUT_W'(acc) < OUT_W'(limit_quotient)) ||
               ((OUT_W'(acc) == OUT_W'(limit_quotient)) && (head.tok.digit <= limit_digit));
    acc_next = acc * VALUE_WIDTH'(radix) + VALUE_WIDTH'(head.tok.digit);
    cnt_next = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
  end

  // Conversion state; a terminator rearms it.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      seen <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else if (take_digit) begin
      seen <= 1'b1;
      cnt  <= cnt_next;
      if (!ovf) begin
        if (in_range) acc <= acc_next;
        else          ovf <= 1'b1;
      end
    end else if (take_term) begin
      acc  <= '0;
      seen <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take_term) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded when a terminator leaves the queue.
  always_ff @(posedge clk) begin
    if (take_term) begin
      res_count <= DCOUNT_W'(cnt);
      priority if (ovf) begin
        res_value  <= OUT_W'(error_value[VALUE_WIDTH-1:0]);
        res_status <= STATUS_OVERFLOW;
        res_force  <= 1'b1;
      end else if (!seen) begin
        res_value  <= '0;
        res_status <= STATUS_NO_DIGITS;
        res_force  <= 1'b0;
      end else begin
        res_value  <= OUT_W'(acc);
        res_status <= STATUS_OK;
        res_force  <= 1'b0;
      end
    end
  end

endmodule

/* sv/radix_digit_accumulator.sv */
// Top level of the radix digit accumulator: configuration registers, front, queue, back.
//
//  Channel  Signals                      Transaction
//  s        s_tvalid s_tready s_tdata    one character in
//  m        m_tvalid m_tready m_tdata    one converted number out (on each terminator)
//           m_tuser
//  cfg      cfg_valid cfg_ready          one register write
//           cfg_index cfg_data
//
// One character per cycle is accepted while the queue has room; the back end's
// multiply-add and limit check on the 64-bit accumulator are combinational.
// A result reaches m through the token queue and then the result register.
// Reset is synchronous; it restores the registers and rearms the conversion.
// Digits keep flowing while a result waits; a second terminator waits in the
// two-entry queue, and s stalls only once that queue is full.
`include "radix_digit_accumulator_macros.svh"

module radix_digit_accumulator import rda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,    // [7:0] char_code
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [79:0]           m_tdata,    // [63:0] value, [79:64] digits_consumed
  output logic [2:0]            m_tuser,    // [1:0] status, [2] force_positive
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIGIT_W-1:0]  radix;
  logic [LIMIT_W-1:0]  limit_quotient;
  logic [DIGIT_W-1:0]  limit_digit;
  logic [OUT_W-1:0]    error_value;

  logic                q_full;
  logic                q_push;
  token_t              q_tok;
  logic                q_pop;
  queue_head_t         q_head;

  logic [OUT_W-1:0]    res_value;
  status_t             res_status;
  logic [DCOUNT_W-1:0] res_count;
  logic                res_force;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix          <= 6'd10;
      limit_quotient <= 63'd1844674407370955161;
      limit_digit    <= 6'd5;
      error_value    <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIX:          radix          <= cfg_data[DIGIT_W-1:0];
        REG_LIMIT_QUOTIENT: limit_quotient <= cfg_data[LIMIT_W-1:0];
        REG_LIMIT_DIGIT:    limit_digit    <= cfg_data[DIGIT_W-1:0];
        REG_ERROR_VALUE:    error_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  rda_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .radix    (radix),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (q_tok)
  );

  rda_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (q_tok),
    .pop      (q_pop),
    .full     (q_full),
    .head     (q_head)
  );

  rda_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .pop            (q_pop),
    .radix          (radix),
    .limit_quotient (limit_quotient),
    .limit_digit    (limit_digit),
    .error_value    (error_value),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_value      (res_value),
    .res_status     (res_status),
    .res_count      (res_count),
    .res_force      (res_force)
  );

  // Pack the result onto the master side.
  assign m_tdata = {res_count, res_value};
  assign m_tuser = {res_force, res_status};

  // Overflow results always carry the force-positive flag, and only they do.
  `RDA_ASSERT_NOW(a_force_matches_ovf, m_tvalid, res_force == (res_status == STATUS_OVERFLOW), "force_positive disagrees with overflow status")
  // A result without digits reports zero value and zero count.
  `RDA_ASSERT_NOW(a_no_digits_zero, m_tvalid && res_status == STATUS_NO_DIGITS, res_value == '0 && res_count == '0, "no-digit result is not zero")
  // A successful conversion consumed at least one digit.
  `RDA_ASSERT_NOW(a_ok_has_digits, m_tvalid && res_status == STATUS_OK, res_count != '0, "ok result with zero digit count")
  // A radix write lands in the register on the next cycle.
  `RDA_ASSERT_NEXT(a_radix_write, cfg_valid && cfg_ready && cfg_index == REG_RADIX, radix == $past(cfg_data[DIGIT_W-1:0]), "radix register missed a write")

endmodule
